FILE: rtl/bmsa_pkg.sv
package bmsa_pkg;

	localparam int NUM_SETS = 4;
	localparam int NUM_BINS = 256;
	localparam int DEPTH    = NUM_SETS * NUM_BINS;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int SUM_W = 48;
	localparam int SQ_W  = 56;
	localparam int CNT_W = 24;
	localparam int ENT_W = 1 + CNT_W + SQ_W + SUM_W;

	localparam int DIV_N = 48;
	localparam int DIV_D = 24;
	localparam int RAD_W = 64;
	localparam int ROOT_W = RAD_W / 2;

	typedef enum logic [2:0] {
		REQ_SUBMIT  = 3'd0,
		REQ_QUERY   = 3'd1,
		REQ_LD_CNT  = 3'd2,
		REQ_LD_SQ   = 3'd3,
		REQ_REMOVE  = 3'd4,
		REQ_CLR_ALL = 3'd5
	} req_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_DIV1,
		ST_MUL1,
		ST_MUL2,
		ST_RAD,
		ST_SQRT,
		ST_DIV2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              present;
		logic [CNT_W-1:0]  cnt;
		logic [SQ_W-1:0]   sq;
		logic [SUM_W-1:0]  sum;
	} entry_t;

	typedef struct packed {
		logic              done;
		logic [DIV_N-1:0]  quot;
	} div_rsp_t;

	typedef struct packed {
		logic               done;
		logic [ROOT_W-1:0]  root;
	} sqrt_rsp_t;

endpackage

FILE: rtl/binned_mean_stderr_accumulator_core.sv
// Per-bin mean and standard error accumulator.
// Requests enter on the s_ stream: s_tuser carries the request kind, s_tdata the set,
// bin, Q8.8 sample and 56-bit load value. Every request gives exactly one report on
// the m_ stream: m_tuser is the present flag, m_tdata the mean, standard error,
// count and sum of squares of the addressed bin after the request.
// Requests are handled one at a time; s_tready is high only while the sequencer idles.
// A request on an invalid set or bin, or one that leaves its bin with a zero count,
// passes through accept, memory read, write back and output load.
// A request that leaves its bin with a nonzero count runs the shared 48-bit divider
// twice and the square root once.
// Clear all sweeps the whole store, one entry per cycle (NUM_SETS * NUM_BINS entries,
// 1024 by default), and then reports zeros.
// After reset the same sweep runs before the first request is taken.
// The report sits in an output register; the next request can be accepted while it
// waits, and a finished report waits for the register to drain when m_tready is low.
module binned_mean_stderr_accumulator_core import bmsa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,   // req_type
	input  logic [87:0]  s_tdata,   // set_index, bin_index, sample_value, load_value, zeros
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [0:0]   m_tuser,   // bin_present
	output logic [111:0] m_tdata    // mean_value, std_error, sample_count, square_sum
);

	state_t state_q, state_nx;

	logic [2:0]         req_q;
	logic               valid_q;
	logic               clr_req_q;
	logic [ADDR_W-1:0]  addr_q;
	logic signed [15:0] smp_q;
	logic [SQ_W-1:0]    load_q;
	entry_t             rd_q;
	entry_t             ent_q;
	logic               rep_pres_q;
	logic signed [15:0] mean_q;
	logic [15:0]        se_q;
	logic signed [63:0] prod_q;
	logic               out_vld_q;
	logic [0:0]         out_user_q;
	logic [111:0]       out_data_q;

	entry_t mem [DEPTH];

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	entry_t             mem_wdata;
	entry_t             upd;
	logic               upd_we;
	logic               div_start;
	logic [DIV_N-1:0]   div_dvd;
	logic [DIV_D-1:0]   div_dvs;
	div_rsp_t           div_rsp;
	logic               sqrt_start;
	logic [RAD_W-1:0]   rad;
	sqrt_rsp_t          sqrt_rsp;
	logic               out_load;
	logic               out_free;
	logic               in_acc;

	logic [1:0]           in_set;
	logic [7:0]           in_bin;
	logic [ADDR_W-1:0]    in_addr;
	logic                 in_valid;
	logic signed [SUM_W:0] sum_nx;
	logic [31:0]          smp_sq;
	logic [SQ_W:0]        sq_nx;
	logic [SUM_W-1:0]     sum_abs;
	logic [DIV_N-1:0]     q_mag;
	logic signed [15:0]   mean_sat;
	logic signed [64:0]   rad_full;

	assign in_set   = s_tdata[1:0];
	assign in_bin   = s_tdata[9:2];
	assign in_valid = (int'(in_set) < NUM_SETS) && (int'(in_bin) < NUM_BINS);
	assign in_addr  = ADDR_W'(ADDR_W'(in_set) * ADDR_W'(NUM_BINS) + ADDR_W'(in_bin));
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// New entry contents for a modifying request.
	always_comb begin
		entry_t base;
		base = rd_q.present ? rd_q : '0;
		base.present = 1'b1;
		upd    = base;
		upd_we = 1'b0;
		sum_nx = {base.sum[SUM_W-1], base.sum} + {{(SUM_W-15){smp_q[15]}}, smp_q};
		smp_sq = 32'(32'(smp_q) * 32'(smp_q));
		sq_nx  = {1'b0, base.sq} + {(SQ_W-31)'(0), smp_sq};
		case (req_q)
			REQ_SUBMIT: begin
				upd_we = valid_q;
				if (sum_nx[SUM_W] != sum_nx[SUM_W-1])
					upd.sum = sum_nx[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
				else
					upd.sum = sum_nx[SUM_W-1:0];
				upd.sq  = sq_nx[SQ_W] ? '1 : sq_nx[SQ_W-1:0];
				upd.cnt = (&base.cnt) ? base.cnt : base.cnt + 1'b1;
			end
			REQ_LD_CNT: begin
				upd_we  = valid_q;
				upd.cnt = (|load_q[SQ_W-1:CNT_W]) ? '1 : load_q[CNT_W-1:0];
			end
			REQ_LD_SQ: begin
				upd_we = valid_q;
				upd.sq = load_q;
			end
			REQ_REMOVE: begin
				upd_we = valid_q;
				upd    = '0;
			end
			default: begin
				upd = rd_q;
			end
		endcase
	end

	// The mean division starts while the entry is written back, so it takes the new contents.
	assign sum_abs = upd.sum[SUM_W-1] ? SUM_W'(-upd.sum) : upd.sum;
	assign q_mag   = div_rsp.quot;

	always_comb begin
		if (ent_q.sum[SUM_W-1]) begin
			if (q_mag > DIV_N'(32768))
				mean_sat = 16'sh8000;
			else
				mean_sat = 16'(-q_mag[15:0]);
		end else begin
			if (q_mag > DIV_N'(32767))
				mean_sat = 16'sh7fff;
			else
				mean_sat = q_mag[15:0];
		end
	end

	assign rad_full = $signed({9'b0, ent_q.sq}) - {prod_q[63], prod_q};
	assign rad      = rad_full[64] ? '0 : rad_full[63:0];

	always_comb begin
		state_nx   = state_q;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = upd;
		div_start  = 1'b0;
		div_dvd    = sum_abs;
		div_dvs    = ent_q.cnt;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		s_tready   = 1'b0;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				if (addr_q == ADDR_W'(DEPTH - 1))
					state_nx = clr_req_q ? ST_OUT : ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_nx = (s_tuser == REQ_CLR_ALL) ? ST_CLR : ST_RD;
			end
			ST_RD: state_nx = ST_UPD;
			ST_UPD: begin
				mem_we  = upd_we;
				div_dvs = upd.cnt;
				if (valid_q && upd.present && upd.cnt != '0) begin
					div_start = 1'b1;
					state_nx  = ST_DIV1;
				end else begin
					state_nx = ST_OUT;
				end
			end
			ST_DIV1: if (div_rsp.done) state_nx = ST_MUL1;
			ST_MUL1: state_nx = ST_MUL2;
			ST_MUL2: begin
				state_nx = ST_RAD;
			end
			// The product is complete here, so the radicand is ready for the root.
			ST_RAD: begin
				sqrt_start = 1'b1;
				state_nx   = ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_rsp.done) begin
					div_start = 1'b1;
					div_dvd   = {(DIV_N-ROOT_W)'(0), sqrt_rsp.root};
					state_nx  = ST_DIV2;
				end
			end
			ST_DIV2: if (div_rsp.done) state_nx = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			out_vld_q <= 1'b0;
			clr_req_q <= 1'b0;
			addr_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
			if (in_acc) begin
				clr_req_q <= (s_tuser == REQ_CLR_ALL);
				addr_q    <= (s_tuser == REQ_CLR_ALL) ? '0 : (in_valid ? in_addr : '0);
			end else if (state_q == ST_CLR) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q      <= s_tuser;
			valid_q    <= in_valid;
			smp_q      <= s_tdata[25:10];
			load_q     <= s_tdata[81:26];
			rep_pres_q <= 1'b0;
			mean_q     <= '0;
			se_q       <= '0;
			ent_q      <= '0;
		end
		case (state_q)
			ST_UPD: begin
				ent_q      <= upd;
				rep_pres_q <= valid_q && upd.present;
			end
			ST_DIV1: if (div_rsp.done) mean_q <= mean_sat;
			ST_MUL1: prod_q <= 64'(41'(mean_q) * 41'($signed({1'b0, ent_q.sum[CNT_W-1:0]})));
			ST_MUL2: prod_q <= prod_q
				+ (64'(40'(mean_q) * 40'($signed(ent_q.sum[SUM_W-1:CNT_W]))) <<< CNT_W);
			ST_DIV2: if (div_rsp.done) se_q <= (|q_mag[DIV_N-1:16]) ? 16'hffff : q_mag[15:0];
			default: ;
		endcase
		if (out_load) begin
			out_user_q <= rep_pres_q;
			if (rep_pres_q)
				out_data_q <= {ent_q.sq, ent_q.cnt, se_q, mean_q};
			else
				out_data_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[addr_q];
	end

	bmsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.rsp      (div_rsp)
	);

	bmsa_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (rad),
		.rsp      (sqrt_rsp)
	);

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = out_data_q;

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || m_tready)) else $error("report overwrote a pending one");
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLR || state_q == ST_UPD)) else $error("stray store write");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE && !div_rsp.done) else $error("accept while busy");

endmodule

FILE: rtl/bmsa_div.sv
module bmsa_div import bmsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_N-1:0] dividend,
	input  logic [DIV_D-1:0] divisor,
	output div_rsp_t         rsp
);

	localparam int CW = $clog2(DIV_N + 1);

	logic [DIV_D-1:0] rem_q;
	logic [DIV_N-1:0] quo_q;
	logic [DIV_D-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_D:0]   rem_sh;
	logic [DIV_D+1:0] diff;

	assign rem_sh = {rem_q, quo_q[DIV_N-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle; the remainder stays below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIV_D+1]) begin
				rem_q <= diff[DIV_D-1:0];
				quo_q <= {quo_q[DIV_N-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_D-1:0];
				quo_q <= {quo_q[DIV_N-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == CW'(DIV_N)) else $error("divider load failed");

endmodule

FILE: rtl/bmsa_sqrt.sv
module bmsa_sqrt import bmsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RAD_W-1:0] radicand,
	output sqrt_rsp_t        rsp
);

	localparam int CW = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  x_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic [ROOT_W+2:0] diff;

	assign rem_sh = {rem_q[ROOT_W-1:0], x_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign diff   = {1'b0, rem_sh} - {1'b0, trial};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Digit-by-digit square root, two radicand bits per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[RAD_W-3:0], 2'b00};
			if (!diff[ROOT_W+2]) begin
				rem_q  <= diff[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("square root started while busy");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("square root done while busy");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == CW'(ROOT_W)) else $error("square root load failed");

endmodule
